### sv/ipv6c_pkg.sv
// ipv6c_pkg: shared types and constants of the ipv6 pseudo-header checksum block
// no dependencies; used by ipv6c_front, ipv6c_queue, ipv6c_back and the top level
package ipv6c_pkg;

   // word classes on the request channel
   localparam logic [1:0] MODE_ADDR    = 2'd0;
   localparam logic [1:0] MODE_NEXTHDR = 2'd1;
   localparam logic [1:0] MODE_HEADER  = 2'd2;
   localparam logic [1:0] MODE_PAYLOAD = 2'd3;

   // queue between classifier and accumulator
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_BITS = 2;

   // one classified word: masked data, counted bytes (0..2), end of packet
   typedef struct packed {
      logic [15:0] word;
      logic [1:0]  nbytes;
      logic        last;
   } ipv6c_entry_type;

endpackage

### sv/ipv6_pseudo_header_checksum.sv
// ipv6_pseudo_header_checksum: top level, classifier, queue and accumulator
// depends on ipv6c_pkg, ipv6c_front, ipv6c_queue, ipv6c_back
//
// Usage: stream one packet as 16-bit big-endian words on the req_ channel:
// address words, the next-header value, then header and payload words, the
// final word with req_last set. One checksum word appears on the rsp_ channel
// per packet. The csr_ channel writes the udp_zero_rule bit (csr_ready is
// always high); write it only while no packet is in flight.
// Throughput: one word per cycle while req_stall is low, set by the accumulate loop.
// Path of the last accepted word: queue, accumulate into the finish stage, then
// fold into the output register, which drives the checksum.
// When the receiver stalls, the checksum holds in the output register, one
// more finished packet waits in the finish stage, and words keep filling the
// four-word queue; req_stall rises only when the queue is full.
// Reset clears the sum, the byte total, the queue and udp_zero_rule.
module ipv6_pseudo_header_checksum #(
   parameter int LENGTH_BITS = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_mode,
   input  logic [15:0] req_data_word,
   input  logic [1:0]  req_bytes_valid,
   input  logic        req_last,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [15:0] rsp_checksum,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_udp_zero_rule
);

   ipv6c_pkg::ipv6c_entry_type cls_entry;
   ipv6c_pkg::ipv6c_entry_type head;
   logic                       q_full, q_empty, q_pop, push;
   logic                       udp_zero_rule_ff, udp_zero_rule_in;

   // configuration register
   assign csr_ready        = 1'b1;
   assign udp_zero_rule_in = (csr_valid && csr_ready) ? csr_udp_zero_rule : udp_zero_rule_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         udp_zero_rule_ff <= 1'b0;
      end else begin
         udp_zero_rule_ff <= udp_zero_rule_in;
      end
   end

   // input handshake
   assign req_stall = q_full;
   assign push      = req_valid && !req_stall;

   ipv6c_front u_front (
      .mode        (req_mode),
      .data_word   (req_data_word),
      .bytes_valid (req_bytes_valid),
      .last        (req_last),
      .entry       (cls_entry)
   );

   ipv6c_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (cls_entry),
      .full       (q_full),
      .pop        (q_pop),
      .empty      (q_empty),
      .head       (head)
   );

   ipv6c_back #(
      .LENGTH_BITS (LENGTH_BITS)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .udp_zero_rule (udp_zero_rule_ff),
      .empty         (q_empty),
      .head          (head),
      .pop           (q_pop),
      .out_valid     (rsp_valid),
      .out_stall     (rsp_stall),
      .out_checksum  (rsp_checksum)
   );

endmodule

### sv/ipv6c_front.sv
// ipv6c_front: classifies one request word into a masked word and a byte count
// depends on ipv6c_pkg
module ipv6c_front (
   input  logic [1:0]                 mode,
   input  logic [15:0]                data_word,
   input  logic [1:0]                 bytes_valid,
   input  logic                       last,
   output ipv6c_pkg::ipv6c_entry_type entry
);

   logic [1:0] nb;

   // saturate the byte count, a value of three acts as two
   assign nb = (bytes_valid == 2'd3) ? 2'd2 : bytes_valid;

   // per-class masking of the word and byte counting
   always_comb begin
      entry.last   = last;
      entry.word   = 16'h0000;
      entry.nbytes = 2'd0;
      case (mode)
         ipv6c_pkg::MODE_ADDR: begin
            entry.word = data_word;
         end
         ipv6c_pkg::MODE_NEXTHDR: begin
            entry.word = {8'h00, data_word[7:0]};
         end
         ipv6c_pkg::MODE_HEADER, ipv6c_pkg::MODE_PAYLOAD: begin
            entry.nbytes = nb;
            case (nb)
               2'd1:    entry.word = {data_word[15:8], 8'h00};
               2'd2:    entry.word = data_word;
               default: entry.word = 16'h0000;
            endcase
         end
         default: begin
            entry.word = 16'h0000;
         end
      endcase
   end

endmodule

### sv/ipv6c_queue.sv
// ipv6c_queue: short first-in first-out queue of classified words
// depends on ipv6c_pkg
module ipv6c_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  ipv6c_pkg::ipv6c_entry_type push_entry,
   output logic                       full,
   input  logic                       pop,
   output logic                       empty,
   output ipv6c_pkg::ipv6c_entry_type head
);

   ipv6c_pkg::ipv6c_entry_type             slot_ff [ipv6c_pkg::QUEUE_DEPTH];
   logic [ipv6c_pkg::QUEUE_PTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [ipv6c_pkg::QUEUE_PTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [ipv6c_pkg::QUEUE_PTR_BITS:0]     count_ff, count_in;

   assign full  = (count_ff == (ipv6c_pkg::QUEUE_PTR_BITS+1)'(ipv6c_pkg::QUEUE_DEPTH));
   assign empty = (count_ff == '0);
   assign head  = slot_ff[rd_ptr_ff];

   // pointer and occupancy update
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage, no reset needed
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

### sv/ipv6c_back.sv
// ipv6c_back: accumulates the ones'-complement sum and byte total, finishes the
// checksum and holds it in the output register; depends on ipv6c_pkg
module ipv6c_back #(
   parameter int LENGTH_BITS = 32
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       udp_zero_rule,
   input  logic                       empty,
   input  ipv6c_pkg::ipv6c_entry_type head,
   output logic                       pop,
   output logic                       out_valid,
   input  logic                       out_stall,
   output logic [15:0]                out_checksum
);

   logic [15:0]            sum_ff, sum_in;
   logic [LENGTH_BITS-1:0] total_ff, total_in;
   logic                   fin_valid_ff, fin_valid_in;
   logic [15:0]            fin_sum_ff;
   logic [LENGTH_BITS-1:0] fin_total_ff;
   logic                   out_valid_ff, out_valid_in;
   logic [15:0]            out_ck_ff;

   logic                   out_free, fin_move, fin_free;
   logic [15:0]            acc_sum;
   logic [LENGTH_BITS-1:0] acc_total;
   logic [31:0]            tot32;
   logic [15:0]            fold_lo, fold_hi, ck;

   // end-around carry add of two 16-bit words
   function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
      logic [16:0] t;
      begin
         t = {1'b0, a} + {1'b0, b};
         oc_add = t[15:0] + {15'd0, t[16]};
      end
   endfunction

   // flow control through finish and output stages
   assign out_free  = !out_valid_ff || !out_stall;
   assign fin_move  = fin_valid_ff && out_free;
   assign fin_free  = !fin_valid_ff || fin_move;
   assign pop       = !empty && fin_free;

   // accumulate one word
   assign acc_sum   = oc_add(sum_ff, head.word);
   assign acc_total = total_ff + LENGTH_BITS'(head.nbytes);

   always_comb begin
      sum_in   = sum_ff;
      total_in = total_ff;
      if (pop) begin
         if (head.last) begin
            sum_in   = 16'h0000;
            total_in = '0;
         end else begin
            sum_in   = acc_sum;
            total_in = acc_total;
         end
      end
   end

   assign fin_valid_in = (pop && head.last) || (fin_valid_ff && !fin_move);

   // fold the byte total into the sum and invert
   assign tot32   = 32'(fin_total_ff);
   assign fold_lo = oc_add(fin_sum_ff, tot32[15:0]);
   assign fold_hi = oc_add(fold_lo, tot32[31:16]);

   always_comb begin
      ck = ~fold_hi;
      if (udp_zero_rule && (ck == 16'h0000)) begin
         ck = 16'hFFFF;
      end
   end

   assign out_valid_in = fin_move || (out_valid_ff && out_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff       <= 16'h0000;
         total_ff     <= '0;
         fin_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         sum_ff       <= sum_in;
         total_ff     <= total_in;
         fin_valid_ff <= fin_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers of the finish and output stages
   always_ff @(posedge clock) begin
      if (pop && head.last) begin
         fin_sum_ff   <= acc_sum;
         fin_total_ff <= acc_total;
      end
      if (fin_move) begin
         out_ck_ff <= ck;
      end
   end

   assign out_valid    = out_valid_ff;
   assign out_checksum = out_ck_ff;

endmodule
